// ===== rtl/lpb_pkg.sv =====
`default_nettype none

package lpb_pkg;

	// Number format and sigmoid table shape
	localparam int FRAC_BITS      = 16;
	localparam int SIG_SEGMENTS   = 64;
	localparam int MAX_EXPAND_DEF = 8;

	// Field and register widths
	localparam int DATA_W   = 32;
	localparam int LAMBDA_W = 24;
	localparam int TOL_W    = 16;
	localparam int ITER_W   = 5;
	localparam int HW_W     = 31;
	localparam int LABEL_W  = 17;
	localparam int CFG_W    = 31;
	localparam int CFG_IDX_W = 2;

	// Sigmoid table and residual widths
	localparam int SIG_W  = FRAC_BITS + 2;
	localparam int SEG_W  = $clog2(SIG_SEGMENTS);
	localparam int IDX_W  = $clog2(SIG_SEGMENTS + 1);
	localparam int SPAN_W = FRAC_BITS + 4;
	localparam int DIFF_W = DATA_W + 1;
	localparam int PROD_W = LAMBDA_W + 1 + DIFF_W;
	localparam int F_W    = PROD_W - FRAC_BITS + 1;

	// Register reset values
	localparam logic [LAMBDA_W-1:0] LAMBDA_RST   = LAMBDA_W'(65536);
	localparam logic [TOL_W-1:0]    TOL_RST      = TOL_W'(0);
	localparam logic [ITER_W-1:0]   MAX_ITER_RST = ITER_W'(5);
	localparam logic [HW_W-1:0]     HW_RST       = HW_W'(655360);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LAMBDA   = 2'd0,
		REG_TOL      = 2'd1,
		REG_MAX_ITER = 2'd2,
		REG_HW       = 2'd3
	} cfg_reg_t;

	// Which bracket point a residual evaluation belongs to
	typedef enum logic [1:0] {
		TAG_LO  = 2'd0,
		TAG_HI  = 2'd1,
		TAG_MID = 2'd2
	} tag_t;

	typedef struct packed {
		logic load;
		logic issue;
		tag_t tag;
		logic swap;
		logic expand;
		logic set_mid;
		logic step;
		logic out_load;
	} lpb_cmd_t;

	typedef struct packed {
		logic busy;
		logic same_sign;
		logic within_tol;
	} lpb_sts_t;

	typedef logic signed [SIG_W-1:0] sig_tab_t [0:SIG_SEGMENTS];

	localparam longint unsigned Q31_ONE = 64'h8000_0000;
	localparam longint unsigned ONE_FX  = 64'd1 << FRAC_BITS;

	localparam logic signed [SIG_W-1:0] SIG_ONE  = SIG_W'(ONE_FX);
	localparam logic signed [DIFF_W-1:0] SIG_BIAS = DIFF_W'(ONE_FX << 3);

	// Build sigmoid breakpoints from a truncated series for e^-t, squared 8 times
	function automatic sig_tab_t build_sig_tab();
		sig_tab_t tab;
		longint d;
		longint unsigned ad, y, y2, y3, y4, e, den, s, num, rem;
		for (int k = 0; k <= SIG_SEGMENTS; k++) begin
			d  = longint'(16) * k - longint'(8) * SIG_SEGMENTS;
			ad = (d < 0) ? longint'(-d) : longint'(d);
			y  = (ad << 23) / SIG_SEGMENTS;
			y2 = ((y * y) >> 31) / 2;
			y3 = ((y2 * y) >> 31) / 3;
			y4 = ((y3 * y) >> 31) / 4;
			e  = (Q31_ONE + y2 + y4) - (y + y3);
			for (int i = 0; i < 8; i++) begin
				e = (e * e + (Q31_ONE >> 1)) >> 31;
			end
			den = Q31_ONE + e;
			// Round to nearest by shift-and-subtract long division
			num = (ONE_FX << 31) + (den >> 1);
			rem = 64'd0;
			s   = 64'd0;
			for (int b = 63; b >= 0; b--) begin
				rem = (rem << 1) | ((num >> b) & 64'd1);
				if (rem >= den) begin
					rem = rem - den;
					s   = s | (64'd1 << b);
				end
			end
			tab[k] = (d < 0) ? SIG_W'(ONE_FX - s) : SIG_W'(s);
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TAB = build_sig_tab();

	// Clamp a 33-bit value to the signed 32-bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
		logic signed [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/lpb_eval.sv =====
`default_nettype none

module lpb_eval import lpb_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       issue,
	input  wire tag_t                       issue_tag,
	input  wire logic signed [DATA_W-1:0]   z,
	input  wire logic signed [DATA_W-1:0]   q,
	input  wire logic [LAMBDA_W-1:0]        lambda_gain,
	input  wire logic [LABEL_W-1:0]         lab,
	output logic                            busy,
	output logic                            f_valid,
	output tag_t                            f_tag,
	output logic signed [F_W-1:0]           f
);

	localparam int P_W = SPAN_W + SEG_W;

	logic signed [DIFF_W-1:0] u;
	logic [P_W-1:0]           p;
	logic [SEG_W-1:0]         seg;
	logic [IDX_W-1:0]         idx;

	logic                     v_s1, v_s2;
	tag_t                     tag_s1, tag_s2;
	logic signed [DIFF_W-1:0] d_s1;
	logic                     under_s1, over_s1;
	logic [SPAN_W-1:0]        r_s1;
	logic signed [SIG_W-1:0]  tab_lo_s1, tab_hi_s1;

	logic signed [SIG_W:0]              diff;
	logic signed [SIG_W+SPAN_W+1:0]     iprod;
	logic signed [SIG_W-1:0]            interp;
	logic signed [LAMBDA_W:0]           lam_s;
	logic signed [PROD_W-1:0]           pprod;
	logic signed [SIG_W-1:0]            sig_s2;
	logic signed [F_W-1:0]              prox_s2;

	// Locate the sigmoid segment of z
	always_comb begin
		u   = DIFF_W'(z) + SIG_BIAS;
		p   = P_W'(u[SPAN_W-1:0]) * P_W'(SIG_SEGMENTS);
		seg = p[P_W-1:SPAN_W];
		idx = IDX_W'(seg);
	end

	// Stage 1: distance to q, segment ends, in-segment offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1    <= issue_tag;
		d_s1      <= DIFF_W'(z) - DIFF_W'(q);
		under_s1  <= u[DIFF_W-1];
		over_s1   <= !u[DIFF_W-1] && (u[DIFF_W-2:SPAN_W] != '0);
		r_s1      <= p[SPAN_W-1:0];
		tab_lo_s1 <= SIG_TAB[idx];
		tab_hi_s1 <= SIG_TAB[idx + IDX_W'(1)];
	end

	// Stage 2: interpolate sigmoid and scale the proximal term
	always_comb begin
		diff   = (SIG_W+1)'(tab_hi_s1) - (SIG_W+1)'(tab_lo_s1);
		iprod  = diff * $signed({1'b0, r_s1});
		interp = tab_lo_s1 + SIG_W'(iprod >>> SPAN_W);
		lam_s  = $signed({1'b0, lambda_gain});
		pprod  = lam_s * d_s1;
	end

	always_ff @(posedge clk) begin
		tag_s2  <= tag_s1;
		sig_s2  <= under_s1 ? '0 : (over_s1 ? SIG_ONE : interp);
		prox_s2 <= F_W'(pprod >>> FRAC_BITS);
	end

	// Combine into the residual
	assign f       = F_W'(sig_s2) + prox_s2 - F_W'($signed({1'b0, lab}));
	assign f_valid = v_s2;
	assign f_tag   = tag_s2;
	assign busy    = v_s1 | v_s2;

endmodule

`default_nettype wire

// ===== rtl/lpb_datapath.sv =====
`default_nettype none

module lpb_datapath import lpb_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lpb_cmd_t                   cmd,
	output lpb_sts_t                        sts,
	input  wire logic [LAMBDA_W-1:0]        lambda_gain,
	input  wire logic [TOL_W-1:0]           tolerance,
	input  wire logic [HW_W-1:0]            half_width,
	input  wire logic signed [DATA_W-1:0]   margin,
	input  wire logic signed [DATA_W-1:0]   offset,
	input  wire logic [LABEL_W-1:0]         label,
	input  wire logic                       last_item,
	output logic signed [DATA_W-1:0]        root,
	output logic                            bracket_failed,
	output logic                            converged,
	output logic                            last_result
);

	logic signed [DATA_W-1:0] q_q, lo_q, hi_q, mid_q;
	logic [LABEL_W-1:0]       lab_q;
	logic                     last_q, failed_q;
	logic signed [F_W-1:0]    flo_q, fhi_q, fmid_q;

	logic signed [DATA_W-1:0] ev_z;
	logic                     ev_busy, ev_valid;
	tag_t                     ev_tag;
	logic signed [F_W-1:0]    ev_f;

	logic signed [DATA_W-1:0] nlo, nhi, dbl_lo, dbl_hi;
	logic signed [DATA_W:0]   sum_cur, sum_new;
	logic signed [F_W-1:0]    tol_s;

	// Pick the bracket point to evaluate
	always_comb begin
		case (cmd.tag)
			TAG_LO:  ev_z = lo_q;
			TAG_HI:  ev_z = hi_q;
			TAG_MID: ev_z = mid_q;
			default: ev_z = mid_q;
		endcase
	end

	lpb_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (cmd.issue),
		.issue_tag   (cmd.tag),
		.z           (ev_z),
		.q           (q_q),
		.lambda_gain (lambda_gain),
		.lab         (lab_q),
		.busy        (ev_busy),
		.f_valid     (ev_valid),
		.f_tag       (ev_tag),
		.f           (ev_f)
	);

	// Bracket arithmetic: doubling, halving step, midpoints
	always_comb begin
		dbl_lo  = sat32({lo_q, 1'b0});
		dbl_hi  = sat32({hi_q, 1'b0});
		nlo     = fmid_q[F_W-1] ? mid_q : lo_q;
		nhi     = fmid_q[F_W-1] ? hi_q : mid_q;
		sum_cur = (DATA_W+1)'(lo_q) + (DATA_W+1)'(hi_q);
		sum_new = (DATA_W+1)'(nlo) + (DATA_W+1)'(nhi);
		tol_s   = F_W'($signed({1'b0, tolerance}));
	end

	// Status for the controller
	always_comb begin
		sts.busy       = ev_busy;
		sts.same_sign  = (flo_q > 0 && fhi_q > 0) || (flo_q < 0 && fhi_q < 0);
		sts.within_tol = (fmid_q <= tol_s) && (fmid_q >= -tol_s);
	end

	// Load request, update bracket
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q    <= sat32((DATA_W+1)'(margin) + (DATA_W+1)'(offset));
			lab_q  <= label;
			last_q <= last_item;
			lo_q   <= -$signed({1'b0, half_width});
			hi_q   <= $signed({1'b0, half_width});
		end else if (cmd.swap) begin
			if (flo_q > fhi_q) begin
				lo_q <= hi_q;
				hi_q <= lo_q;
			end
		end else if (cmd.expand) begin
			if (flo_q > 0) begin
				hi_q <= lo_q;
				lo_q <= dbl_lo;
			end else begin
				lo_q <= hi_q;
				hi_q <= dbl_hi;
			end
		end else if (cmd.step) begin
			lo_q <= nlo;
			hi_q <= nhi;
		end
		if (cmd.set_mid) begin
			mid_q    <= sum_cur[DATA_W:1];
			failed_q <= sts.same_sign;
		end else if (cmd.step) begin
			mid_q <= sum_new[DATA_W:1];
		end
	end

	// Capture residuals, swap with the bracket ends
	always_ff @(posedge clk) begin
		if (ev_valid) begin
			case (ev_tag)
				TAG_LO:  flo_q  <= ev_f;
				TAG_HI:  fhi_q  <= ev_f;
				TAG_MID: fmid_q <= ev_f;
				default: fmid_q <= ev_f;
			endcase
		end else if (cmd.swap && (flo_q > fhi_q)) begin
			flo_q <= fhi_q;
			fhi_q <= flo_q;
		end
	end

	// Hold the result for the output channel
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			root           <= mid_q;
			bracket_failed <= failed_q;
			converged      <= sts.within_tol;
			last_result    <= last_q;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lpb_ctrl.sv =====
`default_nettype none

module lpb_ctrl import lpb_pkg::*; #(
	parameter int MAX_EXPAND = MAX_EXPAND_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire logic [ITER_W-1:0] max_iter,
	input  wire lpb_sts_t          sts,
	output lpb_cmd_t               cmd
);

	localparam int EXP_W = $clog2(MAX_EXPAND + 2);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_ISSUE_LO  = 10'b00_0000_0010,
		ST_ISSUE_HI  = 10'b00_0000_0100,
		ST_WAIT_PAIR = 10'b00_0000_1000,
		ST_SWAP      = 10'b00_0001_0000,
		ST_CHECK     = 10'b00_0010_0000,
		ST_ISSUE_MID = 10'b00_0100_0000,
		ST_WAIT_MID  = 10'b00_1000_0000,
		ST_TEST      = 10'b01_0000_0000,
		ST_DONE      = 10'b10_0000_0000
	} state_t;

	state_t             state_q, state_d;
	logic [EXP_W-1:0]   exp_q;
	logic [ITER_W-1:0]  its_q;
	logic               out_valid_q;
	logic               accept, slot_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || !out_stall;

	// Sequence the search
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.tag = TAG_MID;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d  = ST_ISSUE_LO;
				end
			end
			ST_ISSUE_LO: begin
				cmd.issue = 1'b1;
				cmd.tag   = TAG_LO;
				state_d   = ST_ISSUE_HI;
			end
			ST_ISSUE_HI: begin
				cmd.issue = 1'b1;
				cmd.tag   = TAG_HI;
				state_d   = ST_WAIT_PAIR;
			end
			ST_WAIT_PAIR: begin
				if (!sts.busy) begin
					state_d = (exp_q == '0) ? ST_SWAP : ST_CHECK;
				end
			end
			ST_SWAP: begin
				cmd.swap = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.same_sign && (exp_q < EXP_W'(MAX_EXPAND))) begin
					cmd.expand = 1'b1;
					state_d    = ST_ISSUE_LO;
				end else begin
					cmd.set_mid = 1'b1;
					state_d     = ST_ISSUE_MID;
				end
			end
			ST_ISSUE_MID: begin
				cmd.issue = 1'b1;
				cmd.tag   = TAG_MID;
				state_d   = ST_WAIT_MID;
			end
			ST_WAIT_MID: begin
				if (!sts.busy) begin
					state_d = ST_TEST;
				end
			end
			ST_TEST: begin
				if (!sts.within_tol && (its_q < max_iter)) begin
					cmd.step = 1'b1;
					state_d  = ST_ISSUE_MID;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Advance state, counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			exp_q       <= '0;
			its_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				exp_q <= '0;
				its_q <= '0;
			end else begin
				if (cmd.expand) exp_q <= exp_q + EXP_W'(1);
				if (cmd.step)   its_q <= its_q + ITER_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/logistic_prox_bisection.sv =====
// Logistic proximal solver: for each request it forms q = sat(margin + offset)
// and bisects for z with sigmoid(z) + lambda_gain*(z - q) - label = 0, starting
// from [-half_width, +half_width], doubling the bracket up to MAX_EXPAND times
// (bracket_failed flags no sign change) and halving up to max_iter times or
// until |f| <= tolerance. One request is in work at a time, and every
// evaluation shares the two-stage residual evaluator (a 24x33 multiplier and
// an interpolating sigmoid table). A finished result waits in the output
// register while the next request is taken. The user must write registers
// through cfg_we/cfg_index/cfg_data only while idle; the block itself does
// not enforce this.
`default_nettype none

module logistic_prox_bisection import lpb_pkg::*; #(
	parameter int MAX_EXPAND = MAX_EXPAND_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [DATA_W-1:0] margin,
	input  wire logic signed [DATA_W-1:0] offset,
	input  wire logic [LABEL_W-1:0]       label,
	input  wire logic                     last_item,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      root,
	output logic                          bracket_failed,
	output logic                          converged,
	output logic                          last_result
);

	logic [LAMBDA_W-1:0] lambda_gain_q;
	logic [TOL_W-1:0]    tolerance_q;
	logic [ITER_W-1:0]   max_iter_q;
	logic [HW_W-1:0]     half_width_q;

	lpb_cmd_t cmd;
	lpb_sts_t sts;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_gain_q <= LAMBDA_RST;
			tolerance_q   <= TOL_RST;
			max_iter_q    <= MAX_ITER_RST;
			half_width_q  <= HW_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_LAMBDA:   lambda_gain_q <= cfg_data[LAMBDA_W-1:0];
				REG_TOL:      tolerance_q   <= cfg_data[TOL_W-1:0];
				REG_MAX_ITER: max_iter_q    <= cfg_data[ITER_W-1:0];
				REG_HW:       half_width_q  <= cfg_data[HW_W-1:0];
				default: ;
			endcase
		end
	end

	lpb_ctrl #(
		.MAX_EXPAND (MAX_EXPAND)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.max_iter  (max_iter_q),
		.sts       (sts),
		.cmd       (cmd)
	);

	lpb_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.lambda_gain    (lambda_gain_q),
		.tolerance      (tolerance_q),
		.half_width     (half_width_q),
		.margin         (margin),
		.offset         (offset),
		.label          (label),
		.last_item      (last_item),
		.root           (root),
		.bracket_failed (bracket_failed),
		.converged      (converged),
		.last_result    (last_result)
	);

	// A new request never meets residuals still in flight
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !sts.busy)
		else $error("request loaded while evaluator busy");

	// Bracket updates only act on settled residuals
	a_update_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.swap || cmd.expand || cmd.step || cmd.set_mid) |-> !sts.busy)
		else $error("bracket update with residual in flight");

	// A result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten");

	// Output valid follows a result load
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("output valid without result");

endmodule

`default_nettype wire
